### rtl/core/imo_pkg.sv
// Shared constants, types and helpers of the max interval overlap core.
`default_nettype none
package imo_pkg;

	localparam int MAX_INTERVALS = 256;
	localparam int TIME_BITS     = 16;
	localparam int IN_TIME_W     = 16;
	localparam int ROOM_W        = 9;
	localparam int ROOM_MAX      = 511;

	localparam int IDX_W   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
	localparam int ENTRY_W = 2 * TIME_BITS;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_HOLD,
		ST_SCAN,
		ST_DONE
	} imo_state_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} imo_ram_req_t;

	typedef struct packed {
		logic              valid;
		logic [ROOM_W-1:0] room_count;
		logic              overflow;
	} imo_res_t;

	function automatic logic [ROOM_W-1:0] imo_sat_rooms(input logic [CNT_W-1:0] v);
		if (int'(v) > ROOM_MAX) begin
			return ROOM_W'(ROOM_MAX);
		end
		return ROOM_W'(v);
	endfunction

endpackage
`default_nettype wire

### rtl/core/imo_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module imo_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/imo_ctrl.sv
// Load sequencer and overlap scan engine driving the interval memory.
`default_nettype none
module imo_ctrl import imo_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IN_TIME_W-1:0] start_time,
	input  wire logic [IN_TIME_W-1:0] end_time,
	input  wire logic                 has_interval,
	input  wire logic                 last_item,
	output imo_ram_req_t              ram_req,
	input  wire logic [ENTRY_W-1:0]   ram_rdata,
	output imo_res_t                  res,
	input  wire logic                 res_take
);

	imo_state_t           state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic                 ovf_q, ovf_d;
	logic [IDX_W-1:0]     i_q, i_d;
	logic [CNT_W-1:0]     j_q, j_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W-1:0]     best_q, best_d;
	logic [TIME_BITS-1:0] s_q, s_d;

	logic [TIME_BITS-1:0] rd_start, rd_end;
	logic                 hit, full;
	logic [CNT_W-1:0]     cnt_inc, count_new;

	assign rd_start  = ram_rdata[ENTRY_W-1:TIME_BITS];
	assign rd_end    = ram_rdata[TIME_BITS-1:0];
	assign hit       = (rd_start <= s_q) && (s_q < rd_end);
	assign cnt_inc   = cnt_q + CNT_W'(hit);
	assign full      = (count_q == CNT_W'(MAX_INTERVALS));
	assign count_new = (has_interval && !full) ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			best_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			i_q     <= i_d;
			j_q     <= j_d;
			cnt_q   <= cnt_d;
			best_q  <= best_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= s_d;
	end

	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		ovf_d          = ovf_q;
		i_d            = i_q;
		j_d            = j_q;
		cnt_d          = cnt_q;
		best_d         = best_q;
		s_d            = s_q;
		in_ready       = 1'b0;
		ram_req        = '0;
		res.valid      = 1'b0;
		res.room_count = imo_sat_rooms(best_q);
		res.overflow   = ovf_q;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (has_interval && !full) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = count_q[IDX_W-1:0];
						ram_req.wdata = {TIME_BITS'(start_time), TIME_BITS'(end_time)};
					end
					if (has_interval && full) begin
						ovf_d = 1'b1;
					end
					count_d = count_new;
					if (last_item) begin
						i_d = '0;
						if (count_new == '0) begin
							best_d  = '0;
							state_d = ST_DONE;
						end else begin
							best_d  = CNT_W'(1);
							state_d = ST_FETCH;
						end
					end
				end
			end
			ST_FETCH: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = i_q;
				state_d       = ST_HOLD;
			end
			ST_HOLD: begin
				// Entry i is on the read port; keep its start and begin the inner sweep.
				s_d           = rd_start;
				ram_req.re    = 1'b1;
				ram_req.raddr = '0;
				j_d           = CNT_W'(1);
				cnt_d         = '0;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cnt_d = cnt_inc;
				if (j_q == count_q) begin
					if (cnt_inc > best_q) begin
						best_d = cnt_inc;
					end
					if (CNT_W'(i_q) + CNT_W'(1) == count_q) begin
						state_d = ST_DONE;
					end else begin
						i_d     = i_q + IDX_W'(1);
						state_d = ST_FETCH;
					end
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = j_q[IDX_W-1:0];
					j_d           = j_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				res.valid = 1'b1;
				if (res_take) begin
					count_d = '0;
					ovf_d   = 1'b0;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_INTERVALS))
		else $error("entry count beyond capacity");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (j_q != '0) && (j_q <= count_q))
		else $error("inner index outside the stored set");

	a_pass_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_HOLD || state_q == ST_SCAN)
		|-> (count_q != '0) && (best_q != '0))
		else $error("scan running on an empty set or with zero best");

	a_store_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && has_interval && !full)
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("stored interval not counted");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res_take) |=> (count_q == '0) && !ovf_q && (state_q == ST_LOAD))
		else $error("set not cleared after result transfer");

endmodule
`default_nettype wire

### rtl/core/max_interval_overlap_core.sv
// Top level of the max interval overlap core: memory, sequencer and result register.
`default_nettype none
// This core takes half-open intervals [start_time, end_time) one per input
// transfer and stores them in a single interval memory of MAX_INTERVALS
// entries. An input transfer with has_interval low carries no interval. On
// the transfer with last_item high (its own interval, if any, is stored
// first) the core finds, over every stored interval i, the number of stored
// intervals j with start_j <= start_i < end_j, and returns the largest such
// count as room_count: the minimum number of rooms, 0 for an empty set.
// Intervals that arrive while the memory is full are dropped and reported
// through overflow on the result of that set. After the result the set is
// empty again. Loading takes one input transfer per cycle. The final pass
// reads the memory through its single read port, one entry at a time, and
// for each stored interval i sweeps over every stored interval j; it then
// hands the result to the output register. An empty set skips the pass.
// No input transfer is taken during the pass. The result sits in an output
// register, so the core moves on to load the next set while the result
// waits to be taken, unless a second result is already finished behind it.
module max_interval_overlap_core import imo_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IN_TIME_W-1:0] start_time,
	input  wire logic [IN_TIME_W-1:0] end_time,
	input  wire logic                 has_interval,
	input  wire logic                 last_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ROOM_W-1:0]         room_count,
	output logic                      overflow
);

	imo_ram_req_t       ram_req;
	logic [ENTRY_W-1:0] ram_rdata;
	imo_res_t           res;
	logic               res_take;

	logic               out_valid_q;
	logic [ROOM_W-1:0]  room_count_q;
	logic               overflow_q;

	imo_ram #(
		.WIDTH  (ENTRY_W),
		.DEPTH  (MAX_INTERVALS),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	imo_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_time   (start_time),
		.end_time     (end_time),
		.has_interval (has_interval),
		.last_item    (last_item),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.res          (res),
		.res_take     (res_take)
	);

	// The output register takes a new result whenever it is empty or its
	// current result leaves in the same cycle.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			room_count_q <= res.room_count;
			overflow_q   <= res.overflow;
		end
	end

	assign out_valid  = out_valid_q;
	assign room_count = room_count_q;
	assign overflow   = overflow_q;

endmodule
`default_nettype wire
